/* rtl/assert_macros.svh */
// Assertion macros for the checker file of this block.
// Every macro clocks on the rising edge of the given clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that is checked only while the active-low reset is released.
`define FC1D_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Property that is checked at every edge, including edges during reset.
`define FC1D_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/fc1d_pkg.sv */
`timescale 1ns / 1ps

package fc1d_pkg;

  // Coefficient registers and their format.
  localparam int unsigned COEF_COUNT = 7;
  localparam int unsigned COEF_BITS  = 16;

  // Configuration port.
  localparam int unsigned CFG_IDX_BITS  = 4;
  localparam int unsigned CFG_DATA_BITS = 16;
  localparam int unsigned HW_BITS       = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_BITS-1:0] REG_HALF_WIDTH = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_BASE  = 4'd1;

  // Reset value of the half width register.
  localparam logic [HW_BITS-1:0] HALF_WIDTH_RESET = 2'd2;

  // Control that travels with a word from one pipeline stage to the next.
  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

endpackage

/* rtl/fc1d_if.sv */
`timescale 1ns / 1ps

// Input sample channel.
interface fc1d_sample_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          sample_last;

  modport source (output valid, output sample, output sample_last, input ready);
  modport sink   (input valid, input sample, input sample_last, output ready);
endinterface

// Filter result channel.
interface fc1d_result_if #(
  parameter int unsigned OUT_BITS = 34
);
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] filtered;
  logic                       result_last;

  modport source (output valid, output filtered, output result_last, input ready);
  modport sink   (input valid, input filtered, input result_last, output ready);
endinterface

// Configuration write channel.
interface fc1d_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [fc1d_pkg::CFG_IDX_BITS-1:0]  index;
  logic [fc1d_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/fc1d_mac.sv */
`timescale 1ns / 1ps

// Multiply stage and sum stage of the filter. The sum stage is the output
// register of the block.
module fc1d_mac #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned USE_TAPS    = 7,
  parameter int unsigned OUT_BITS    = 34
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  fc1d_pkg::stage_ctl_t                    ctl_i,
  output logic                                    ready_o,
  input  logic signed [SAMPLE_BITS-1:0]           window_i [USE_TAPS],
  input  logic signed [fc1d_pkg::COEF_BITS-1:0]   coef_i   [USE_TAPS],
  fc1d_result_if.source                           result_o
);
  import fc1d_pkg::*;

  localparam int unsigned PROD_BITS = SAMPLE_BITS + COEF_BITS;

  stage_ctl_t                  mul_ctl_q, mul_ctl_d;
  stage_ctl_t                  sum_ctl_q, sum_ctl_d;
  logic signed [PROD_BITS-1:0] prod_q [USE_TAPS];
  logic signed [OUT_BITS-1:0]  sum_q, sum_d;
  logic                        sum_rdy;
  logic                        mul_rdy;

  // A stage moves when it is empty or when its successor takes its word.
  assign sum_rdy = !sum_ctl_q.valid || result_o.ready;
  assign mul_rdy = !mul_ctl_q.valid || sum_rdy;
  assign ready_o = mul_rdy;

  always_comb begin
    mul_ctl_d = mul_ctl_q;
    sum_ctl_d = sum_ctl_q;
    if (mul_rdy) begin
      mul_ctl_d = ctl_i;
    end
    if (sum_rdy) begin
      sum_ctl_d = mul_ctl_q;
    end
  end

  // Products are sign extended and added at the output width; the wrap at
  // the top bit is the intended truncation of the sum.
  always_comb begin
    sum_d = '0;
    for (int m = 0; m < USE_TAPS; m++) begin
      sum_d = sum_d + OUT_BITS'(prod_q[m]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_ctl_q <= '0;
      sum_ctl_q <= '0;
    end else begin
      mul_ctl_q <= mul_ctl_d;
      sum_ctl_q <= sum_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_rdy && ctl_i.valid) begin
      for (int m = 0; m < USE_TAPS; m++) begin
        prod_q[m] <= window_i[m] * coef_i[m];
      end
    end
    if (sum_rdy && mul_ctl_q.valid) begin
      sum_q <= sum_d;
    end
  end

  assign result_o.valid       = sum_ctl_q.valid;
  assign result_o.result_last = sum_ctl_q.last;
  assign result_o.filtered    = sum_q;

endmodule

/* rtl/fir_convolution_1d.sv */
`timescale 1ns / 1ps

// Channel   Modport  Word                        Accepted when
// -------   -------  --------------------------  ---------------------
// sample_i  sink     sample, sample_last         sample_i.valid & ready
// result_o  source   filtered, result_last       result_o.valid & ready
// cfg_i     sink     index, data (register write) cfg_i.valid & ready
//
// One sample word is taken every clock unless the pipeline is stalled. A
// result passes the window register, product register and sum register in
// turn before it leaves the output register. Each stage holds its word
// only while the stage after it is full and stalled, so a stall on result_o
// backs up into sample_i.ready after the three stages have filled. Reset is
// asynchronous and active low; it restores half_width to 2, clears every
// coefficient, the delay line and the fill count, and empties the pipeline.
module fir_convolution_1d #(
  parameter int unsigned MAX_TAPS    = 7,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  fc1d_sample_if.sink    sample_i,
  fc1d_result_if.source  result_o,
  fc1d_cfg_if.sink       cfg_i
);
  import fc1d_pkg::*;

  // Full-precision sum width: one sample times one coefficient, plus two
  // guard bits for the sum of up to seven products.
  localparam int unsigned OUT_BITS = SAMPLE_BITS + COEF_BITS + 2;
  // Taps that can ever be used: the register set holds COEF_COUNT
  // coefficients and the tap count never exceeds MAX_TAPS.
  localparam int unsigned USE_TAPS = (MAX_TAPS < COEF_COUNT) ? MAX_TAPS : COEF_COUNT;
  // The delay line keeps the previous samples; keep one entry even for a
  // single-tap build so the array is never empty.
  localparam int unsigned DEPTH = (USE_TAPS > 1) ? USE_TAPS - 1 : 1;
  // The counter must hold MAX_TAPS and also the largest programmable tap count.
  localparam int unsigned CNT_MAX  = (MAX_TAPS > COEF_COUNT) ? MAX_TAPS : COEF_COUNT;
  localparam int unsigned CNT_BITS = $clog2(CNT_MAX + 1);
  localparam logic [CNT_BITS-1:0] MAX_TAPS_C = CNT_BITS'(MAX_TAPS);

  // Configuration registers.
  logic [HW_BITS-1:0]          half_width_q;
  logic signed [COEF_BITS-1:0] coef_q [COEF_COUNT];
  logic signed [COEF_BITS-1:0] coef_use [USE_TAPS];

  // Stream state.
  logic signed [SAMPLE_BITS-1:0] delay_q [DEPTH];
  logic [CNT_BITS-1:0]           fill_q, fill_d;

  // Window register: the first pipeline stage.
  stage_ctl_t                    win_ctl_q, win_ctl_d;
  logic signed [SAMPLE_BITS-1:0] win_q [USE_TAPS];
  logic signed [SAMPLE_BITS-1:0] win_d [USE_TAPS];

  logic                accept;
  logic                win_rdy;
  logic                mac_rdy;
  logic [CNT_BITS-1:0] taps_raw;
  logic [CNT_BITS-1:0] taps;
  logic [CNT_BITS-1:0] have;
  logic                produce;

  // Configuration writes are always taken. Writes to an index past the
  // last coefficient are dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_q <= HALF_WIDTH_RESET;
      for (int j = 0; j < COEF_COUNT; j++) begin
        coef_q[j] <= '0;
      end
    end else if (cfg_i.valid) begin
      if (cfg_i.index == REG_HALF_WIDTH) begin
        half_width_q <= cfg_i.data[HW_BITS-1:0];
      end
      for (int j = 0; j < COEF_COUNT; j++) begin
        if (cfg_i.index == REG_COEF_BASE + CFG_IDX_BITS'(j)) begin
          coef_q[j] <= cfg_i.data[COEF_BITS-1:0];
        end
      end
    end
  end

  for (genvar m = 0; m < USE_TAPS; m++) begin : g_coef
    assign coef_use[m] = coef_q[m];
  end

  // The tap count 2*half_width+1 is the half width with a one appended,
  // clamped to the build's tap limit.
  assign taps_raw = CNT_BITS'({half_width_q, 1'b1});
  assign taps     = (taps_raw > MAX_TAPS_C) ? MAX_TAPS_C : taps_raw;

  // Samples of the current vector including this one, saturating at the
  // tap limit. A vector shorter than the tap count yields nothing, and its
  // last flag goes with it.
  assign have    = (fill_q >= MAX_TAPS_C) ? MAX_TAPS_C : fill_q + 1'b1;
  assign produce = (have >= taps);

  assign win_rdy        = !win_ctl_q.valid || mac_rdy;
  assign sample_i.ready = win_rdy;
  assign accept         = sample_i.valid && win_rdy;

  // Taps beyond the current count get a zero sample, so the product stage
  // needs no tap mask of its own.
  for (genvar m = 0; m < USE_TAPS; m++) begin : g_win
    if (m == 0) begin : g_newest
      assign win_d[m] = sample_i.sample;
    end else begin : g_older
      assign win_d[m] = (CNT_BITS'(m) < taps) ? delay_q[m-1] : '0;
    end
  end

  always_comb begin
    win_ctl_d = win_ctl_q;
    fill_d    = fill_q;
    if (win_rdy) begin
      win_ctl_d.valid = accept && produce;
      win_ctl_d.last  = sample_i.sample_last;
    end
    if (accept) begin
      fill_d = sample_i.sample_last ? '0 : have;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_ctl_q <= '0;
      fill_q    <= '0;
      for (int j = 0; j < DEPTH; j++) begin
        delay_q[j] <= '0;
      end
    end else begin
      win_ctl_q <= win_ctl_d;
      fill_q    <= fill_d;
      if (accept) begin
        // The last flag leaves the delay line alone; older entries are
        // never used because the fill count gates every result.
        delay_q[0] <= sample_i.sample;
        for (int j = 1; j < DEPTH; j++) begin
          delay_q[j] <= delay_q[j-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && produce) begin
      for (int m = 0; m < USE_TAPS; m++) begin
        win_q[m] <= win_d[m];
      end
    end
  end

  fc1d_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .USE_TAPS    (USE_TAPS),
    .OUT_BITS    (OUT_BITS)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (win_ctl_q),
    .ready_o  (mac_rdy),
    .window_i (win_q),
    .coef_i   (coef_use),
    .result_o (result_o)
  );

endmodule

/* rtl/fc1d_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Port-level checks on the filter's sample and result channels.
module fc1d_checker #(
  parameter int unsigned OUT_BITS = 34
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic signed [OUT_BITS-1:0] filtered_i,
  input logic                       result_last_i
);

  logic              stalled;
  logic [OUT_BITS:0] out_word;

  assign stalled  = out_valid_i && !out_ready_i;
  assign out_word = {filtered_i, result_last_i};

  // A result word that is not taken stays offered.
  `FC1D_ASSERT(a_out_valid_hold, clk_i, rst_ni, stalled |=> out_valid_i, "valid dropped in stall")

  // A stalled result word keeps its payload.
  `FC1D_ASSERT(a_out_word_hold, clk_i, rst_ni, stalled |=> $stable(out_word), "word changed")

  // With the output register empty the whole pipeline can move.
  `FC1D_ASSERT(a_ready_when_drained, clk_i, rst_ni, !out_valid_i |-> in_ready_i, "input held off")

  // The edge after a reset edge sees an empty output register.
  `FC1D_ASSERT_ALWAYS(a_quiet_in_reset, clk_i, !rst_ni |=> !out_valid_i, "result offered in reset")

endmodule

bind fir_convolution_1d fc1d_checker #(
  .OUT_BITS (OUT_BITS)
) u_fc1d_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (sample_i.ready),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .filtered_i    (result_o.filtered),
  .result_last_i (result_o.result_last)
);

/* verif/tb_top.sv */
`timescale 1ns / 1ps

// Testbench for the streaming odd-length FIR filter. It drives sample words
// and register writes, predicts every filtered word from its own copy of
// the filter state, and checks the words that leave the block in order.
module tb_top;
  import fc1d_pkg::*;

  localparam int unsigned MAX_TAPS     = 7;
  localparam int unsigned SAMPLE_BITS  = 16;
  localparam int unsigned OUT_BITS     = 34;
  // The pipeline is three stages deep; the drain wait covers any bubble
  // that is still on its way when the last filtered word has left.
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned PHASE_ITEMS  = 130;
  localparam int unsigned PHASE_COUNT  = 6;
  localparam int unsigned MAX_PRINTS   = 50;

  // How the expected filtered word of a directed row is obtained.
  typedef enum logic [1:0] {
    EXP_PRED,
    EXP_NONE,
    EXP_VAL
  } exp_kind_e;

  typedef enum logic [1:0] {
    ROW_SAMPLE,
    ROW_REG,
    ROW_COEFS
  } row_kind_e;

  // One directed row. For a sample row, val is the sample and lst its last
  // flag; for a register row, idx and val form the write. ROW_COEFS writes
  // val into every coefficient.
  typedef struct packed {
    row_kind_e                   kind;
    logic [CFG_IDX_BITS-1:0]     idx;
    logic [CFG_DATA_BITS-1:0]    val;
    logic                        lst;
    exp_kind_e                   chk;
    logic signed [OUT_BITS-1:0]  y;
    logic                        y_last;
  } dir_row_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] filtered;
    logic                       last;
  } fir_out_t;

  localparam int unsigned DIR_COUNT = 31;

  localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
    // After reset: five taps, all coefficients zero. The first four samples
    // are edge positions, the fifth yields a zero sum and ends the vector.
    '{ROW_SAMPLE, 4'd0, 16'h7FFF, 1'b0, EXP_NONE, 34'sd0, 1'b0},
    '{ROW_SAMPLE, 4'd0, 16'h8000, 1'b0, EXP_NONE, 34'sd0, 1'b0},
    '{ROW_SAMPLE, 4'd0, 16'h0001, 1'b0, EXP_NONE, 34'sd0, 1'b0},
    '{ROW_SAMPLE, 4'd0, 16'hFFFF, 1'b0, EXP_NONE, 34'sd0, 1'b0},
    '{ROW_SAMPLE, 4'd0, 16'h1234, 1'b1, EXP_VAL, 34'sd0, 1'b1},
    // A vector of one sample is too short and its last flag is dropped.
    '{ROW_SAMPLE, 4'd0, 16'h0005, 1'b1, EXP_NONE, 34'sd0, 1'b0},
    // A single tap of full negative scale.
    '{ROW_REG, REG_HALF_WIDTH, 16'd0, 1'b0, EXP_NONE, 34'sd0, 1'b0},
    '{ROW_REG, REG_COEF_BASE, 16'h8000, 1'b0, EXP_NONE, 34'sd0, 1'b0},
    '{ROW_SAMPLE, 4'd0, 16'h8000, 1'b0, EXP_VAL, 34'sd1073741824, 1'b0},
    '{ROW_SAMPLE, 4'd0, 16'h7FFF, 1'b1, EXP_VAL, -34'sd1073709056, 1'b1},
    // Seven taps, every product at its largest: the top of the sum range.
    '{ROW_REG, REG_HALF_WIDTH, 16'd3, 1'b0, EXP_NONE, 34'sd0, 1'b0},
    '{ROW_COEFS, 4'd0, 16'h8000, 1'b0, EXP_NONE, 34'sd0, 1'b0},
    '{ROW_SAMPLE, 4'd0, 16'h8000, 1'b0, EXP_NONE, 34'sd0, 1'b0},
    '{ROW_SAMPLE, 4'd0, 16'h8000, 1'b0, EXP_NONE, 34'sd0, 1'b0},
    '{ROW_SAMPLE, 4'd0, 16'h8000, 1'b0, EXP_NONE, 34'sd0, 1'b0},
    '{ROW_SAMPLE, 4'd0, 16'h8000, 1'b0, EXP_NONE, 34'sd0, 1'b0},
    '{ROW_SAMPLE, 4'd0, 16'h8000, 1'b0, EXP_NONE, 34'sd0, 1'b0},
    '{ROW_SAMPLE, 4'd0, 16'h8000, 1'b0, EXP_NONE, 34'sd0, 1'b0},
    '{ROW_SAMPLE, 4'd0, 16'h8000, 1'b0, EXP_VAL, 34'sd7516192768, 1'b0},
    '{ROW_SAMPLE, 4'd0, 16'h7FFF, 1'b0, EXP_PRED, 34'sd0, 1'b0},
    // Three taps from here on, while the vector is still open: the full
    // fill count lets the next sample produce at once from held samples.
    '{ROW_REG, REG_HALF_WIDTH, 16'd1, 1'b0, EXP_NONE, 34'sd0, 1'b0},
    '{ROW_SAMPLE, 4'd0, 16'd100, 1'b1, EXP_PRED, 34'sd0, 1'b0},
    // Seven taps again with stale samples in the delay line, then the
    // bottom of the sum range.
    '{ROW_COEFS, 4'd0, 16'h7FFF, 1'b0, EXP_NONE, 34'sd0, 1'b0},
    '{ROW_REG, REG_HALF_WIDTH, 16'd3, 1'b0, EXP_NONE, 34'sd0, 1'b0},
    '{ROW_SAMPLE, 4'd0, 16'h8000, 1'b0, EXP_NONE, 34'sd0, 1'b0},
    '{ROW_SAMPLE, 4'd0, 16'h8000, 1'b0, EXP_NONE, 34'sd0, 1'b0},
    '{ROW_SAMPLE, 4'd0, 16'h8000, 1'b0, EXP_NONE, 34'sd0, 1'b0},
    '{ROW_SAMPLE, 4'd0, 16'h8000, 1'b0, EXP_NONE, 34'sd0, 1'b0},
    '{ROW_SAMPLE, 4'd0, 16'h8000, 1'b0, EXP_NONE, 34'sd0, 1'b0},
    '{ROW_SAMPLE, 4'd0, 16'h8000, 1'b0, EXP_NONE, 34'sd0, 1'b0},
    '{ROW_SAMPLE, 4'd0, 16'h8000, 1'b1, EXP_VAL, -34'sd7515963392, 1'b1}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  fc1d_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) smp_if ();
  fc1d_result_if #(.OUT_BITS(OUT_BITS))       res_if ();
  fc1d_cfg_if                                 cfg_if ();

  fir_convolution_1d #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .sample_i (smp_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Filter state as the testbench sees it, updated at each accepted word.
  logic [HW_BITS-1:0]            fir_half_width;
  logic signed [COEF_BITS-1:0]   fir_coef [COEF_COUNT];
  logic signed [SAMPLE_BITS-1:0] fir_delay [MAX_TAPS-1];
  int unsigned                   fir_fill;

  // Filtered words still to come, oldest first.
  fir_out_t fir_expect_q [$];

  // Handshake counters that let the drivers see an acceptance.
  int unsigned smp_taken = 0;
  int unsigned cfg_taken = 0;
  int unsigned err_count = 0;
  int unsigned stall_cycles = 0;

  // The expectation that goes with the sample word now on offer.
  exp_kind_e                  cur_chk = EXP_PRED;
  logic signed [OUT_BITS-1:0] cur_y = '0;
  logic                       cur_y_last = 1'b0;

  // Idle rates in percent, and a request for a long hold-off of the
  // result channel, which the receiver serves in its own process.
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned hold_asks = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  function automatic void fir_reset();
    fir_half_width = HALF_WIDTH_RESET;
    for (int m = 0; m < COEF_COUNT; m++) fir_coef[m] = '0;
    for (int m = 0; m < MAX_TAPS - 1; m++) fir_delay[m] = '0;
    fir_fill = 0;
  endfunction

  function automatic void fir_write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                                        input logic [CFG_DATA_BITS-1:0] data);
    if (idx == REG_HALF_WIDTH) begin
      fir_half_width = data[HW_BITS-1:0];
    end else if (idx >= REG_COEF_BASE && idx < REG_COEF_BASE + COEF_COUNT) begin
      fir_coef[idx - REG_COEF_BASE] = data[COEF_BITS-1:0];
    end
  endfunction

  // Takes one sample word into the filter state. Returns 1 when the word
  // completes a full window, with the sum of products in y.
  function automatic logic fir_filter_step(input logic signed [SAMPLE_BITS-1:0] s,
                                           input logic lst,
                                           output logic signed [OUT_BITS-1:0] y);
    int unsigned               taps;
    int unsigned               have;
    logic signed [SAMPLE_BITS-1:0] tap_val;
    logic signed [31:0]        prod;
    logic                      produced;
    taps = 2 * fir_half_width + 1;
    if (taps > MAX_TAPS) taps = MAX_TAPS;
    have = fir_fill + 1;
    if (have > MAX_TAPS) have = MAX_TAPS;
    y = '0;
    produced = (have >= taps);
    if (produced) begin
      for (int m = 0; m < taps; m++) begin
        tap_val = (m == 0) ? s : fir_delay[m-1];
        prod = fir_coef[m] * tap_val;
        y = y + prod;
      end
    end
    for (int m = MAX_TAPS - 2; m > 0; m--) fir_delay[m] = fir_delay[m-1];
    fir_delay[0] = s;
    fir_fill = lst ? 0 : have;
    return produced;
  endfunction

  task automatic report_mismatch(input string what, input fir_out_t got,
                                 input fir_out_t want);
    err_count++;
    if (err_count <= MAX_PRINTS) begin
      $display("MISMATCH %s at %0t: got filtered=%0d last=%0b, want filtered=%0d last=%0b",
               what, $realtime, got.filtered, got.last, want.filtered, want.last);
    end
  endtask

  // Quarter of the picks are the Q1.15 extremes, zero or minus one LSB.
  function automatic logic [15:0] pick_q15();
    case ($urandom_range(0, 15))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  // Offers one sample word and returns at the falling edge after it was
  // taken. The valid stays high so that the next word can follow at once.
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp, input logic lst,
                             input exp_kind_e chk, input logic signed [OUT_BITS-1:0] y,
                             input logic y_last);
    int unsigned taken0;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      smp_if.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    smp_if.valid       <= 1'b1;
    smp_if.sample      <= smp;
    smp_if.sample_last <= lst;
    cur_chk    = chk;
    cur_y      = y;
    cur_y_last = y_last;
    taken0 = smp_taken;
    do @(negedge clk); while (smp_taken == taken0);
  endtask

  // Register writes are made only while the block is idle; each write
  // lowers the channel's valid again before it returns.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    int unsigned taken0;
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    taken0 = cfg_taken;
    do @(negedge clk); while (cfg_taken == taken0);
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Stops offering samples, waits for every filtered word still owed and
  // then lets words that cause no output run out of the pipeline.
  task automatic wait_idle();
    smp_if.valid <= 1'b0;
    while (fir_expect_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Receiver: random stalls at the current rate, or a long hold-off when
  // one is asked for. With the sender still offering, the hold-off fills
  // the pipeline and must back up into the sample ready.
  always @(negedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen    <= hold_asks;
      hold_left    <= HOLD_CYCLES;
      res_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Sampling at the rising edge. An outgoing word is checked before the
  // sample word of the same edge is predicted, so that a stray output can
  // never be matched against an expectation that was not yet due.
  always @(posedge clk) begin
    logic                       produced;
    logic signed [OUT_BITS-1:0] y;
    fir_out_t                   got;
    fir_out_t                   want;
    if (rst_n) begin
      if (res_if.valid && res_if.ready) begin
        got.filtered = res_if.filtered;
        got.last     = res_if.result_last;
        if (fir_expect_q.size() == 0) begin
          report_mismatch("unexpected word", got, '0);
        end else begin
          want = fir_expect_q.pop_front();
          if (got.filtered !== want.filtered || got.last !== want.last) begin
            report_mismatch("wrong word", got, want);
          end
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        fir_write_reg(cfg_if.index, cfg_if.data);
        cfg_taken++;
      end
      if (smp_if.valid && smp_if.ready) begin
        produced = fir_filter_step(smp_if.sample, smp_if.sample_last, y);
        case (cur_chk)
          EXP_PRED: begin
            if (produced) fir_expect_q.push_back('{filtered: y, last: smp_if.sample_last});
          end
          EXP_VAL: begin
            fir_expect_q.push_back('{filtered: cur_y, last: cur_y_last});
          end
          EXP_NONE: begin
          end
          default: begin
          end
        endcase
        smp_taken++;
      end
    end
  end

  // Watchdog: a long run of cycles with no word moving on any channel
  // means the block has hung or lost a word.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("TIMEOUT at %0t with %0d words still owed", $realtime,
                 fir_expect_q.size());
        $display("RESULT: ERROR");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned          sent;
    int unsigned          len;
    int unsigned          roll;
    int unsigned          taps;
    logic                 open_run;
    logic [HW_BITS-1:0]   hw;
    smp_if.valid       = 1'b0;
    smp_if.sample      = '0;
    smp_if.sample_last = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = '0;
    cfg_if.data        = '0;
    res_if.ready       = 1'b0;
    tx_idle_pct = 32;
    rx_idle_pct = 73;
    fir_reset();
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Directed rows.
    for (int r = 0; r < DIR_COUNT; r++) begin
      case (DIR_ROWS[r].kind)
        ROW_REG: begin
          wait_idle();
          write_reg(DIR_ROWS[r].idx, DIR_ROWS[r].val);
        end
        ROW_COEFS: begin
          wait_idle();
          for (int m = 0; m < COEF_COUNT; m++) begin
            write_reg(REG_COEF_BASE + 4'(m), DIR_ROWS[r].val);
          end
        end
        default: begin
          send_sample(DIR_ROWS[r].val, DIR_ROWS[r].lst, DIR_ROWS[r].chk,
                      DIR_ROWS[r].y, DIR_ROWS[r].y_last);
        end
      endcase
    end

    // Random phases. Each starts from idle with a fresh setting; the
    // previous phase leaves a vector open, so the tap count often changes
    // in the middle of a vector.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      wait_idle();
      case (p / 2)
        0: begin
          tx_idle_pct = 32;
          rx_idle_pct = 73;
        end
        1: begin
          tx_idle_pct = 73;
          rx_idle_pct = 32;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      hw = 2'($urandom_range(0, 3));
      write_reg(REG_HALF_WIDTH, {{(CFG_DATA_BITS-HW_BITS){1'b0}}, hw});
      for (int m = 0; m < COEF_COUNT; m++) begin
        write_reg(REG_COEF_BASE + 4'(m), pick_q15());
      end
      taps = 2 * hw + 1;
      // With no idling on either side, a long hold-off on the results.
      if (p == 4) hold_asks++;

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        roll = $urandom_range(0, 99);
        open_run = 1'b0;
        if (roll < 80) begin
          len = $urandom_range(taps, taps + 12);
        end else if (roll < 90) begin
          len = (taps > 1) ? $urandom_range(1, taps - 1) : 1;
        end else begin
          len = $urandom_range(1, 6);
          open_run = 1'b1;
        end
        for (int i = 0; i < len; i++) begin
          send_sample(pick_q15(), (i == len - 1) && !open_run, EXP_PRED, '0, 1'b0);
        end
        sent += len;
      end
      for (int i = 0; i < 3; i++) send_sample(pick_q15(), 1'b0, EXP_PRED, '0, 1'b0);
    end

    wait_idle();
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/fc1d_pkg.sv
rtl/fc1d_if.sv
rtl/fc1d_mac.sv
rtl/fir_convolution_1d.sv
rtl/fc1d_checker.sv
verif/tb_top.sv
